// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the cksum CRC block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while the active-low reset is asserted.
`define PCRC_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Shorthand on the block clock and reset.
`define PCRC_ASSERT(label, prop) \
    `PCRC_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// ----- rtl/pcrc_pkg.sv -----
// Package for the POSIX cksum CRC-32 block: constants, command/status
// structs and the byte-wise CRC update. No dependencies.
package pcrc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned BYTE_W   = 8;

    typedef struct packed {
        logic take;      // input beat accepted
        logic load_len;  // input beat is last: latch length
        logic fold;      // fold one length byte
        logic emit;      // load result register, clear message state
    } pcrc_cmd_t;

    typedef struct packed {
        logic len_zero;  // no length bytes left to fold
    } pcrc_sts_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] rem,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = rem ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/pcrc_ctrl.sv -----
// Controller for the cksum CRC block: accept / length-fold sequencing
// and the result-beat valid flag. Depends on pcrc_pkg.
module pcrc_ctrl import pcrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  pcrc_sts_t sts,
    output pcrc_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FOLD = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take     = s_valid;
                cmd.load_len = s_valid && s_last;
                if (s_valid && s_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = !sts.len_zero;
                cmd.emit = sts.len_zero && out_free;
                if (cmd.emit) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/pcrc_datapath.sv -----
// Datapath for the cksum CRC block: message and running remainders,
// byte counter, length shifter and result registers. Depends on pcrc_pkg.
module pcrc_datapath import pcrc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  pcrc_cmd_t         cmd,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_has_byte,
    output pcrc_sts_t         sts,
    output logic [CRC_W-1:0]  m_message_crc,
    output logic [CRC_W-1:0]  m_running_total_crc
);

    logic [CRC_W-1:0]  msg_rem_reg, msg_rem_next;
    logic [CRC_W-1:0]  tot_rem_reg, tot_rem_next;
    logic [CRC_W-1:0]  count_reg, count_next;
    logic [CRC_W-1:0]  len_reg, len_next;
    logic [CRC_W-1:0]  out_msg_reg, out_tot_reg;
    logic [CRC_W-1:0]  count_inc;
    logic [BYTE_W-1:0] feed_byte;
    logic              feed_en;
    logic [CRC_W-1:0]  msg_fed, tot_fed;

    assign feed_byte = cmd.fold ? len_reg[BYTE_W-1:0] : s_data_byte;
    assign feed_en   = (cmd.take && s_has_byte) || cmd.fold;
    assign msg_fed   = crc_feed(msg_rem_reg, feed_byte);
    assign tot_fed   = crc_feed(tot_rem_reg, feed_byte);
    assign count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;

    assign sts.len_zero = (len_reg == '0);

    always_comb begin
        msg_rem_next = msg_rem_reg;
        tot_rem_next = tot_rem_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        if (feed_en) begin
            msg_rem_next = msg_fed;
            tot_rem_next = tot_fed;
        end
        if (cmd.take && s_has_byte) begin
            count_next = count_inc;
        end
        if (cmd.load_len) begin
            len_next   = count_next;
            count_next = '0;
        end
        if (cmd.fold) begin
            len_next = len_reg >> BYTE_W;
        end
        if (cmd.emit) begin
            msg_rem_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_rem_reg <= '0;
            tot_rem_reg <= '0;
            count_reg   <= '0;
            len_reg     <= '0;
        end else begin
            msg_rem_reg <= msg_rem_next;
            tot_rem_reg <= tot_rem_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_msg_reg <= ~msg_rem_reg;
            out_tot_reg <= ~tot_rem_reg;
        end
    end

    assign m_message_crc       = out_msg_reg;
    assign m_running_total_crc = out_tot_reg;

endmodule

// ----- rtl/posix_cksum_crc32.sv -----
// POSIX cksum CRC-32 engine. Takes one message byte per beat, one beat per
// cycle, while no message tail is being processed. A beat with last set ends
// the message: its byte (if any) is folded, then the byte count is folded one
// length byte per cycle (zero to four length bytes, set by the length shifter),
// and then the result register is loaded; the input is held off during that
// tail. The result beat carries the inverted message CRC and the inverted
// CRC run over all messages, length bytes included, since reset. A pending
// result does not stall byte beats, but the result load of the next message
// waits until it is taken.
// Depends on pcrc_pkg, pcrc_ctrl, pcrc_datapath and assert_macros.svh.
`include "assert_macros.svh"

module posix_cksum_crc32 import pcrc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_has_byte,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CRC_W-1:0]  m_message_crc,
    output logic [CRC_W-1:0]  m_running_total_crc
);

    pcrc_cmd_t cmd;
    pcrc_sts_t sts;

    pcrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcrc_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .s_data_byte         (s_data_byte),
        .s_has_byte          (s_has_byte),
        .sts                 (sts),
        .m_message_crc       (m_message_crc),
        .m_running_total_crc (m_running_total_crc)
    );

    `PCRC_ASSERT(a_last_blocks_input, s_valid && s_ready && s_last |=> !s_ready)
    `PCRC_ASSERT(a_emit_after_fold, cmd.emit |-> sts.len_zero && !cmd.fold)
    `PCRC_ASSERT(a_no_fold_while_taking, cmd.take |-> !cmd.fold && !cmd.emit)
    `PCRC_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_message_crc))

endmodule
